/* rtl/core/cia_pkg.sv */
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types and constants for the complex integer arithmetic unit.
// ----------------------------------------------------------------------------
package cia_pkg;

    localparam int OUT_W       = 33;
    localparam int PART_W_DEF  = 16;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cia_cmd_t;

    // control that travels with each request through the pipeline
    typedef struct packed {
        logic valid;
        logic is_div;
        logic dz;
        logic neg_re;
        logic neg_im;
    } cia_ctrl_t;

endpackage

/* rtl/core/complex_integer_alu.sv */
// Pipeline: two front stages, one divider stage per quotient bit, one output stage.
// Throughput: one request per cycle; the whole pipeline holds while the
// result is stalled.
// Reset: synchronous active-low aresetn clears all valid bits.
// ----------------------------------------------------------------------------
// complex_integer_alu
// Pipelined complex add, subtract, multiply and truncating divide.
// ----------------------------------------------------------------------------
module complex_integer_alu
    import cia_pkg::*;
#(
    parameter int PART_WIDTH = PART_W_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_command,
    input  logic signed [PART_WIDTH-1:0] s_a_re,
    input  logic signed [PART_WIDTH-1:0] s_a_im,
    input  logic signed [PART_WIDTH-1:0] s_b_re,
    input  logic signed [PART_WIDTH-1:0] s_b_im,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [OUT_W-1:0]      m_res_re,
    output logic signed [OUT_W-1:0]      m_res_im,
    output logic                         m_div_zero
);

    localparam int DW = 2 * PART_WIDTH;
    localparam int MW = 2 * PART_WIDTH + 1;
    localparam int SW = (MW + 1 > OUT_W) ? MW + 1 : OUT_W;

    logic en;

    cia_ctrl_t        ctrl_p   [0:MW];
    logic [DW-1:0]    den_p    [0:MW];
    logic [DW-1:0]    r_re_p   [0:MW];
    logic [DW-1:0]    r_im_p   [0:MW];
    logic [MW-1:0]    q_re_p   [0:MW];
    logic [MW-1:0]    q_im_p   [0:MW];
    logic [OUT_W-1:0] alt_re_p [0:MW];
    logic [OUT_W-1:0] alt_im_p [0:MW];

    logic                    m_valid_reg;
    logic signed [OUT_W-1:0] res_re_reg, res_im_reg;
    logic                    dz_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    cia_front #(.PART_WIDTH(PART_WIDTH)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .command  (s_command),
        .a_re     (s_a_re),
        .a_im     (s_a_im),
        .b_re     (s_b_re),
        .b_im     (s_b_im),
        .ctrl_o   (ctrl_p[0]),
        .den_o    (den_p[0]),
        .mag_re_o (q_re_p[0]),
        .mag_im_o (q_im_p[0]),
        .alt_re_o (alt_re_p[0]),
        .alt_im_o (alt_im_p[0])
    );

    assign r_re_p[0] = '0;
    assign r_im_p[0] = '0;

    for (genvar i = 0; i < MW; i++) begin : g_div
        cia_div_stage #(.PART_WIDTH(PART_WIDTH)) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .ctrl_i   (ctrl_p[i]),
            .den_i    (den_p[i]),
            .r_re_i   (r_re_p[i]),
            .q_re_i   (q_re_p[i]),
            .r_im_i   (r_im_p[i]),
            .q_im_i   (q_im_p[i]),
            .alt_re_i (alt_re_p[i]),
            .alt_im_i (alt_im_p[i]),
            .ctrl_o   (ctrl_p[i+1]),
            .den_o    (den_p[i+1]),
            .r_re_o   (r_re_p[i+1]),
            .q_re_o   (q_re_p[i+1]),
            .r_im_o   (r_im_p[i+1]),
            .q_im_o   (q_im_p[i+1]),
            .alt_re_o (alt_re_p[i+1]),
            .alt_im_o (alt_im_p[i+1])
        );
    end

    // sign fix-up and result select
    cia_ctrl_t               cl;
    logic signed [SW-1:0]    qre_w, qim_w;
    logic signed [OUT_W-1:0] res_re_next, res_im_next;

    always_comb begin
        cl    = ctrl_p[MW];
        qre_w = SW'(q_re_p[MW]);
        qim_w = SW'(q_im_p[MW]);
        if (cl.neg_re) qre_w = -qre_w;
        if (cl.neg_im) qim_w = -qim_w;
        if (cl.dz) begin
            res_re_next = '0;
            res_im_next = '0;
        end else if (cl.is_div) begin
            res_re_next = qre_w[OUT_W-1:0];
            res_im_next = qim_w[OUT_W-1:0];
        end else begin
            res_re_next = alt_re_p[MW];
            res_im_next = alt_im_p[MW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= cl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            dz_reg     <= cl.dz;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_res_re   = res_re_reg;
    assign m_res_im   = res_im_reg;
    assign m_div_zero = dz_reg;

`ifndef NO_ASSERTIONS
    a_dz_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_div_zero |-> m_res_re == '0 && m_res_im == '0)
        else $error("divide-by-zero result not zero");

    a_dz_div : assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_p[MW].dz |-> ctrl_p[MW].is_div)
        else $error("zero-divisor flag on non-divide request");

    a_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res_re) && $stable(m_res_im))
        else $error("result changed while stalled");

    a_stall_front : assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(ctrl_p[0]))
        else $error("front stage moved during stall");
`endif

endmodule

/* rtl/core/cia_front.sv */
// ----------------------------------------------------------------------------
// cia_front
// Two register stages: partial products, then sums, divisor and
// quotient signs/magnitudes for the divider.
// ----------------------------------------------------------------------------
module cia_front
    import cia_pkg::*;
#(
    parameter int PART_WIDTH = PART_W_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [1:0]                  command,
    input  logic signed [PART_WIDTH-1:0] a_re,
    input  logic signed [PART_WIDTH-1:0] a_im,
    input  logic signed [PART_WIDTH-1:0] b_re,
    input  logic signed [PART_WIDTH-1:0] b_im,
    output cia_ctrl_t                   ctrl_o,
    output logic [2*PART_WIDTH-1:0]     den_o,
    output logic [2*PART_WIDTH:0]       mag_re_o,
    output logic [2*PART_WIDTH:0]       mag_im_o,
    output logic [OUT_W-1:0]            alt_re_o,
    output logic [OUT_W-1:0]            alt_im_o
);

    localparam int PW = PART_WIDTH;
    localparam int DW = 2 * PW;
    localparam int MW = 2 * PW + 1;
    localparam int NW = 2 * PW + 2;
    localparam int SW = (NW > OUT_W) ? NW : OUT_W;

    // stage A
    logic                 va_reg;
    cia_cmd_t             cmd_a_reg;
    logic signed [DW-1:0] ac_reg, bd_reg, ad_reg, bc_reg, cc_reg, dd_reg;
    logic signed [PW:0]   sre_reg, sim_reg;

    logic signed [PW:0]   sre_next, sim_next;

    always_comb begin
        if (cia_cmd_t'(command) == CMD_SUB) begin
            sre_next = (PW+1)'(a_re) - (PW+1)'(b_re);
            sim_next = (PW+1)'(a_im) - (PW+1)'(b_im);
        end else begin
            sre_next = (PW+1)'(a_re) + (PW+1)'(b_re);
            sim_next = (PW+1)'(a_im) + (PW+1)'(b_im);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd_a_reg <= cia_cmd_t'(command);
            ac_reg    <= DW'(a_re) * DW'(b_re);
            bd_reg    <= DW'(a_im) * DW'(b_im);
            ad_reg    <= DW'(a_re) * DW'(b_im);
            bc_reg    <= DW'(a_im) * DW'(b_re);
            cc_reg    <= DW'(b_re) * DW'(b_re);
            dd_reg    <= DW'(b_im) * DW'(b_im);
            sre_reg   <= sre_next;
            sim_reg   <= sim_next;
        end
    end

    // stage B
    logic signed [NW-1:0] num_re, num_im, mre, mim;
    logic signed [SW-1:0] alt_re_w, alt_im_w;
    logic [DW-1:0]        den_next;
    cia_ctrl_t            ctrl_next;
    cia_ctrl_t            ctrl_reg;
    logic [DW-1:0]        den_reg;
    logic [MW-1:0]        mag_re_reg, mag_im_reg;
    logic [OUT_W-1:0]     alt_re_reg, alt_im_reg;

    always_comb begin
        num_re   = NW'(ac_reg) + NW'(bd_reg);
        num_im   = NW'(bc_reg) - NW'(ad_reg);
        mre      = NW'(ac_reg) - NW'(bd_reg);
        mim      = NW'(ad_reg) + NW'(bc_reg);
        den_next = DW'($unsigned(cc_reg)) + DW'($unsigned(dd_reg));
        if (cmd_a_reg == CMD_MUL) begin
            alt_re_w = SW'(mre);
            alt_im_w = SW'(mim);
        end else begin
            alt_re_w = SW'(sre_reg);
            alt_im_w = SW'(sim_reg);
        end
        ctrl_next.valid  = va_reg;
        ctrl_next.is_div = (cmd_a_reg == CMD_DIV);
        ctrl_next.dz     = (cmd_a_reg == CMD_DIV) && (den_next == '0);
        ctrl_next.neg_re = num_re[NW-1];
        ctrl_next.neg_im = num_im[NW-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg    <= den_next;
            mag_re_reg <= num_re[NW-1] ? MW'(-num_re) : MW'(num_re);
            mag_im_reg <= num_im[NW-1] ? MW'(-num_im) : MW'(num_im);
            alt_re_reg <= alt_re_w[OUT_W-1:0];
            alt_im_reg <= alt_im_w[OUT_W-1:0];
        end
    end

    assign ctrl_o   = ctrl_reg;
    assign den_o    = den_reg;
    assign mag_re_o = mag_re_reg;
    assign mag_im_o = mag_im_reg;
    assign alt_re_o = alt_re_reg;
    assign alt_im_o = alt_im_reg;

endmodule

/* rtl/core/cia_div_stage.sv */
// ----------------------------------------------------------------------------
// cia_div_stage
// One restoring-division step for both quotient parts, registered.
// ----------------------------------------------------------------------------
module cia_div_stage
    import cia_pkg::*;
#(
    parameter int PART_WIDTH = PART_W_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  cia_ctrl_t               ctrl_i,
    input  logic [2*PART_WIDTH-1:0] den_i,
    input  logic [2*PART_WIDTH-1:0] r_re_i,
    input  logic [2*PART_WIDTH:0]   q_re_i,
    input  logic [2*PART_WIDTH-1:0] r_im_i,
    input  logic [2*PART_WIDTH:0]   q_im_i,
    input  logic [OUT_W-1:0]        alt_re_i,
    input  logic [OUT_W-1:0]        alt_im_i,
    output cia_ctrl_t               ctrl_o,
    output logic [2*PART_WIDTH-1:0] den_o,
    output logic [2*PART_WIDTH-1:0] r_re_o,
    output logic [2*PART_WIDTH:0]   q_re_o,
    output logic [2*PART_WIDTH-1:0] r_im_o,
    output logic [2*PART_WIDTH:0]   q_im_o,
    output logic [OUT_W-1:0]        alt_re_o,
    output logic [OUT_W-1:0]        alt_im_o
);

    localparam int DW = 2 * PART_WIDTH;
    localparam int MW = 2 * PART_WIDTH + 1;

    logic [DW:0] t_re, t_im, d_re, d_im;
    logic        ge_re, ge_im;

    always_comb begin
        t_re  = {r_re_i, q_re_i[MW-1]};
        t_im  = {r_im_i, q_im_i[MW-1]};
        ge_re = t_re >= {1'b0, den_i};
        ge_im = t_im >= {1'b0, den_i};
        d_re  = ge_re ? (t_re - {1'b0, den_i}) : t_re;
        d_im  = ge_im ? (t_im - {1'b0, den_i}) : t_im;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_o <= '0;
        end else if (en) begin
            ctrl_o <= ctrl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_o    <= den_i;
            r_re_o   <= d_re[DW-1:0];
            r_im_o   <= d_im[DW-1:0];
            q_re_o   <= {q_re_i[MW-2:0], ge_re};
            q_im_o   <= {q_im_i[MW-2:0], ge_im};
            alt_re_o <= alt_re_i;
            alt_im_o <= alt_im_i;
        end
    end

endmodule
